@@ hw/rtl/bba_pkg.sv @@
// Shared types and codes of the bump allocator with best-fit reuse.
package bba_pkg;

	localparam int unsigned AW = 31;
	localparam int unsigned EW = 2 * AW;

	typedef enum logic [1:0] {
		OP_ALLOC  = 2'd0,
		OP_FREE   = 2'd1,
		OP_RESIZE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_ZERO     = 3'd1,
		ST_NOSPACE  = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECIDE,
		S_SCAN,
		S_FINISH
	} state_t;

	localparam logic CFG_MAX  = 1'b0;
	localparam logic CFG_INIT = 1'b1;

	localparam logic [AW-1:0] MAX_RESET   = 31'h7FFF_FFFF;
	localparam logic [AW-1:0] INIT_RESET  = 31'd1048576;
	localparam logic [AW-1:0] FIRST_OFFSET = 31'd1;

endpackage

@@ hw/rtl/bump_allocator_best_fit_reuse.sv @@
// Bump allocator with best-fit reuse: a request needs no table walk when it is a bump allocation that
// fits, a resize, a zero size, a no-op or finds the live table full; a free walks the live table and an
// allocation that misses the bump region walks the freed table, one entry read per cycle from
// the table RAM. The result strobe done is high for one cycle; the receiver cannot stall it. A
// new request may start in the cycle that done is shown. Valid bits of both tables are cleared
// at reset, so no clearing pass is needed.
module bump_allocator_best_fit_reuse #(
	parameter int unsigned LIVE_ENTRIES  = 64,
	parameter int unsigned FREED_ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [30:0] addr,
	input  logic [30:0] length,
	output logic        done,
	output logic [30:0] ptr,
	output logic [30:0] freed_size,
	output logic [30:0] mem_size,
	output logic [2:0]  status,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [30:0] cfg_wdata
);

	localparam int unsigned LIW  = $clog2(LIVE_ENTRIES);
	localparam int unsigned FIW  = $clog2(FREED_ENTRIES);
	localparam int unsigned MAXN = (LIVE_ENTRIES > FREED_ENTRIES) ? LIVE_ENTRIES : FREED_ENTRIES;
	localparam int unsigned CW   = $clog2(MAXN + 1);
	localparam int unsigned AW   = bba_pkg::AW;
	localparam int unsigned EW   = bba_pkg::EW;

	bba_pkg::state_t state_q, state_d;

	logic [1:0]    op_q;
	logic [AW-1:0] addr_q, len_q;
	logic [AW-1:0] bump_q, cur_q, max_q;

	logic [LIVE_ENTRIES-1:0]  live_vld_q;
	logic [FREED_ENTRIES-1:0] freed_vld_q;

	logic [CW-1:0] cnt_q, idx_s1;
	logic          rd_s1;

	logic          hit_q;
	logic [CW-1:0] hidx_q;
	logic [AW-1:0] hsize_q, haddr_q;

	logic          live_empty, freed_empty;
	logic [LIW-1:0] live_slot;
	logic [FIW-1:0] freed_slot;

	logic          live_we, freed_we;
	logic [LIW-1:0] live_waddr;
	logic [FIW-1:0] freed_waddr;
	logic [EW-1:0] live_wdata, freed_wdata, live_rdata, freed_rdata;

	logic [AW:0]   end_sum;
	logic [AW+2:0] big_sum;
	logic          is_alloc, is_free, need_scan, issue, scan_done;
	logic [CW-1:0] limit;
	logic [AW-1:0] e_addr, e_size;
	logic          e_vld, better;

	assign is_alloc = (op_q == bba_pkg::OP_ALLOC);
	assign is_free  = (op_q == bba_pkg::OP_FREE);
	assign end_sum  = {1'b0, bump_q} + {1'b0, len_q};
	assign big_sum  = {3'b000, bump_q} + {1'b0, len_q, 2'b00};
	assign need_scan = is_free ||
		(is_alloc && len_q != '0 && live_empty && end_sum > {1'b0, cur_q});
	assign limit = is_free ? CW'(LIVE_ENTRIES) : CW'(FREED_ENTRIES);
	assign issue = (state_q == bba_pkg::S_SCAN) && (cnt_q < limit);
	assign scan_done = (state_q == bba_pkg::S_SCAN) && !issue && !rd_s1;
	assign busy = (state_q != bba_pkg::S_IDLE);

	// find the lowest free slot of each table
	always_comb begin
		live_empty = 1'b0;
		live_slot  = '0;
		for (int i = LIVE_ENTRIES - 1; i >= 0; i--) begin
			if (!live_vld_q[i]) begin
				live_empty = 1'b1;
				live_slot  = LIW'(i);
			end
		end
	end

	always_comb begin
		freed_empty = 1'b0;
		freed_slot  = '0;
		for (int i = FREED_ENTRIES - 1; i >= 0; i--) begin
			if (!freed_vld_q[i]) begin
				freed_empty = 1'b1;
				freed_slot  = FIW'(i);
			end
		end
	end

	// table RAMs, entry is {addr, size}
	bba_ram #(.DEPTH(LIVE_ENTRIES), .WIDTH(EW)) u_live (
		.clk   (clk),
		.we    (live_we),
		.waddr (live_waddr),
		.wdata (live_wdata),
		.re    (issue && is_free),
		.raddr (cnt_q[LIW-1:0]),
		.rdata (live_rdata)
	);

	bba_ram #(.DEPTH(FREED_ENTRIES), .WIDTH(EW)) u_freed (
		.clk   (clk),
		.we    (freed_we),
		.waddr (freed_waddr),
		.wdata (freed_wdata),
		.re    (issue && !is_free),
		.raddr (cnt_q[FIW-1:0]),
		.rdata (freed_rdata)
	);

	// entry coming back from the walked table
	always_comb begin
		if (is_free) begin
			e_addr = live_rdata[EW-1:AW];
			e_size = live_rdata[AW-1:0];
			e_vld  = live_vld_q[idx_s1[LIW-1:0]];
		end else begin
			e_addr = freed_rdata[EW-1:AW];
			e_size = freed_rdata[AW-1:0];
			e_vld  = freed_vld_q[idx_s1[FIW-1:0]];
		end
		if (is_free) begin
			better = e_vld && !hit_q && (e_addr == addr_q);
		end else begin
			better = e_vld && (e_size >= len_q) && (!hit_q || e_size < hsize_q ||
				(e_size == hsize_q && e_addr < haddr_q));
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bba_pkg::S_IDLE:   if (start) state_d = bba_pkg::S_DECIDE;
			bba_pkg::S_DECIDE: state_d = need_scan ? bba_pkg::S_SCAN : bba_pkg::S_FINISH;
			bba_pkg::S_SCAN:   if (scan_done) state_d = bba_pkg::S_FINISH;
			bba_pkg::S_FINISH: state_d = bba_pkg::S_IDLE;
			default:           state_d = bba_pkg::S_IDLE;
		endcase
	end

	// table writes in the finishing cycle
	always_comb begin
		live_we     = 1'b0;
		live_waddr  = live_slot;
		live_wdata  = {bump_q, len_q};
		freed_we    = 1'b0;
		freed_waddr = freed_slot;
		freed_wdata = {addr_q, hsize_q};
		if (state_q == bba_pkg::S_FINISH) begin
			if (is_alloc && len_q != '0 && live_empty) begin
				if (end_sum <= {1'b0, cur_q}) begin
					live_we = 1'b1;
				end else if (hit_q) begin
					live_we    = 1'b1;
					live_wdata = {haddr_q, len_q};
				end else if (end_sum <= {1'b0, max_q}) begin
					live_we = 1'b1;
				end
			end
			if (is_free && hit_q && freed_empty) begin
				freed_we = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bba_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// latch the request
	always_ff @(posedge clk) begin
		if (state_q == bba_pkg::S_IDLE && start) begin
			op_q   <= op;
			addr_q <= addr;
			len_q  <= length;
		end
	end

	// walk counter and best candidate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			idx_s1 <= '0;
			rd_s1  <= 1'b0;
			hit_q  <= 1'b0;
		end else if (state_q == bba_pkg::S_DECIDE) begin
			cnt_q <= '0;
			rd_s1 <= 1'b0;
			hit_q <= 1'b0;
		end else if (state_q == bba_pkg::S_SCAN) begin
			rd_s1  <= issue;
			idx_s1 <= cnt_q;
			if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (rd_s1 && better) begin
				hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == bba_pkg::S_SCAN && rd_s1 && better) begin
			hidx_q  <= idx_s1;
			hsize_q <= e_size;
			haddr_q <= e_addr;
		end
	end

	// allocator state, valid bits, configuration and the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bump_q      <= bba_pkg::FIRST_OFFSET;
			cur_q       <= bba_pkg::INIT_RESET;
			max_q       <= bba_pkg::MAX_RESET;
			live_vld_q  <= '0;
			freed_vld_q <= '0;
			done        <= 1'b0;
			ptr         <= '0;
			freed_size  <= '0;
			mem_size    <= '0;
			status      <= bba_pkg::ST_OK;
		end else begin
			done <= 1'b0;
			if (cfg_we) begin
				if (cfg_idx == bba_pkg::CFG_MAX) begin
					max_q <= cfg_wdata;
				end else begin
					cur_q <= cfg_wdata;
				end
			end
			if (state_q == bba_pkg::S_FINISH) begin
				done       <= 1'b1;
				ptr        <= '0;
				freed_size <= '0;
				mem_size   <= cur_q;
				status     <= bba_pkg::ST_OK;
				case (op_q)
					bba_pkg::OP_ALLOC: begin
						if (len_q == '0) begin
							status <= bba_pkg::ST_ZERO;
						end else if (!live_empty) begin
							status <= bba_pkg::ST_FULL;
						end else if (end_sum <= {1'b0, cur_q}) begin
							live_vld_q[live_slot] <= 1'b1;
							ptr    <= bump_q;
							bump_q <= end_sum[AW-1:0];
						end else if (hit_q) begin
							live_vld_q[live_slot]          <= 1'b1;
							freed_vld_q[hidx_q[FIW-1:0]] <= 1'b0;
							ptr <= haddr_q;
						end else if (end_sum > {1'b0, max_q}) begin
							status <= bba_pkg::ST_NOSPACE;
						end else begin
							// grow memory, then bump
							if (big_sum < {3'b000, max_q}) begin
								cur_q    <= big_sum[AW-1:0];
								mem_size <= big_sum[AW-1:0];
							end else begin
								cur_q    <= end_sum[AW-1:0];
								mem_size <= end_sum[AW-1:0];
							end
							live_vld_q[live_slot] <= 1'b1;
							ptr    <= bump_q;
							bump_q <= end_sum[AW-1:0];
						end
					end
					bba_pkg::OP_FREE: begin
						if (!hit_q) begin
							status <= bba_pkg::ST_NOTFOUND;
						end else if (!freed_empty) begin
							status <= bba_pkg::ST_FULL;
						end else begin
							live_vld_q[hidx_q[LIW-1:0]] <= 1'b0;
							freed_vld_q[freed_slot]     <= 1'b1;
							freed_size <= hsize_q;
						end
					end
					bba_pkg::OP_RESIZE: begin
						cur_q    <= len_q;
						mem_size <= len_q;
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

@@ hw/rtl/bba_ram.sv @@
// Simple dual-port synchronous RAM with registered read data.
module bba_ram #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned WIDTH = 62
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/bba_checker.sv @@
// Port-level checks of the bump allocator, bound to the top level.
module bba_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [30:0] ptr,
	input logic [30:0] freed_size,
	input logic [2:0]  status
);

	// a result only follows a request in progress
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("done without a request in progress");

	// an accepted request makes the block busy
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("request accepted but not busy");

	// status stays within its codes
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status <= bba_pkg::ST_FULL)) else $error("bad status code");

	// a failed request hands out nothing
	a_fail_no_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != bba_pkg::ST_OK) |-> (ptr == '0 && freed_size == '0))
		else $error("pointer or size on a failed request");

endmodule

bind bump_allocator_best_fit_reuse bba_checker u_bba_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.ptr        (ptr),
	.freed_size (freed_size),
	.status     (status)
);
